[design/pvrc_pkg.sv]
// Package for the peak/valley run counter: tracker phase encoding,
// tracker control struct, result word type and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package pvrc_pkg;

   localparam int TOTAL_BITS    = 16;
   localparam int MIN_LEN_BITS  = 16;
   localparam int CSR_IDX_BITS  = 1;
   localparam int RUN_START_LEN = 2;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_PEAK_LEN   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_VALLEY_LEN = 1'b1;

   // LEAD is the run direction that opens the feature (rise for a peak,
   // fall for a valley), TRAIL the one that closes it.
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEAD,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic accept;
      logic first;
      logic last;
      logic lead;
   } trk_ctrl_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] peak_total;
      logic [TOTAL_BITS-1:0] valley_total;
   } result_type;

endpackage

[design/pvrc_tracker.sv]
// One run tracker (used for peaks and for valleys): phase, run length and tally.
// Depends on pvrc_pkg.
`timescale 1ns / 1ps

module pvrc_tracker
   import pvrc_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  trk_ctrl_type            ctrl,
   input  logic [MIN_LEN_BITS-1:0] min_len,
   output logic [TOTAL_BITS-1:0]   total
);

   localparam int CMP_BITS = (COUNT_BITS > MIN_LEN_BITS) ? COUNT_BITS : MIN_LEN_BITS;
   localparam logic [COUNT_BITS-1:0] RUN_START = COUNT_BITS'(RUN_START_LEN);
   localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

   phase_type             phase_ff, phase_in, upd_phase;
   logic [COUNT_BITS-1:0] run_ff, run_in, upd_run;
   logic [COUNT_BITS-1:0] tally_ff, tally_in, upd_tally;
   logic [COUNT_BITS-1:0] run_inc, tally_inc, flush_tally;
   logic                  run_ok, flush_ok;

   assign run_inc   = (run_ff == CNT_MAX) ? run_ff : run_ff + 1'b1;
   assign tally_inc = (tally_ff == CNT_MAX) ? tally_ff : tally_ff + 1'b1;
   assign run_ok    = CMP_BITS'(run_ff) >= CMP_BITS'(min_len);

   always_comb begin
      upd_phase = phase_ff;
      upd_run   = run_ff;
      upd_tally = tally_ff;
      if (ctrl.first) begin
         upd_phase = PH_IDLE;
         upd_run   = '0;
         upd_tally = '0;
      end else begin
         case (phase_ff)
            PH_LEAD: begin
               if (ctrl.lead) begin
                  upd_run = run_inc;
               end else if (run_ok) begin
                  upd_phase = PH_TRAIL;
                  upd_run   = RUN_START;
               end else begin
                  upd_phase = PH_IDLE;
               end
            end
            PH_TRAIL: begin
               if (ctrl.lead) begin
                  if (run_ok) begin
                     upd_tally = tally_inc;
                  end
                  upd_phase = PH_LEAD;
                  upd_run   = RUN_START;
               end else begin
                  upd_run = run_inc;
               end
            end
            default: begin
               // idle only leaves on a lead step
               if (ctrl.lead) begin
                  upd_phase = PH_LEAD;
                  upd_run   = RUN_START;
               end
            end
         endcase
      end
   end

   // an open trailing run that qualifies counts at the end of the sequence
   assign flush_ok    = (upd_phase == PH_TRAIL) &&
                        (CMP_BITS'(upd_run) >= CMP_BITS'(min_len));
   assign flush_tally = (flush_ok && (upd_tally != CNT_MAX)) ? upd_tally + 1'b1 : upd_tally;

   generate
      if (COUNT_BITS > TOTAL_BITS) begin : g_clip
         assign total = (|flush_tally[COUNT_BITS-1:TOTAL_BITS]) ?
                        {TOTAL_BITS{1'b1}} : flush_tally[TOTAL_BITS-1:0];
      end else begin : g_ext
         assign total = TOTAL_BITS'(flush_tally);
      end
   endgenerate

   always_comb begin
      phase_in = phase_ff;
      run_in   = run_ff;
      tally_in = tally_ff;
      if (ctrl.accept) begin
         if (ctrl.last) begin
            phase_in = PH_IDLE;
            run_in   = '0;
            tally_in = '0;
         end else begin
            phase_in = upd_phase;
            run_in   = upd_run;
            tally_in = upd_tally;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         run_ff   <= '0;
         tally_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         tally_ff <= tally_in;
      end
   end

`ifndef SYNTHESIS
   a_open_run_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (run_ff >= RUN_START))
      else $error("open run shorter than two points");
`endif

endmodule

[design/pvrc_out_buf.sv]
// Two-entry result buffer (output register plus skid) for the rsp channel.
// Depends on pvrc_pkg.
`timescale 1ns / 1ps

module pvrc_out_buf
   import pvrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_word,
   output logic       push_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_word
);

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop        = head_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = head_valid_ff;
   assign out_word   = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff || pop) begin
            head_in       = push_word;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid word held with empty output register");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> !skid_valid_ff && head_valid_ff)
      else $error("skid word not moved to output register");
`endif

endmodule

[design/peak_valley_run_counter_core.sv]
// Peak/valley run counter top level: sample compare, two trackers, result buffer.
// Depends on pvrc_pkg, pvrc_tracker and pvrc_out_buf.
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Word
// req      in   req_valid/req_ready    sample, first_sample, last_sample
// rsp      out  rsp_valid/rsp_ready    peak_total, valley_total
// csr      in   csr_write_en           csr_index, csr_wdata (no read-back)
//
// One sample per cycle; the compare and both tracker updates finish in the
// accept cycle and a last word is registered into the output register or the skid.
// Results pass through a two-entry buffer, so req stalls only when both
// entries are full. Reset clears trackers and buffer, sets both minimums to 2
// and the previous sample to the most negative value.

module peak_valley_run_counter_core
   import pvrc_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_first_sample,
   input  logic                          req_last_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic        [TOTAL_BITS-1:0]  rsp_peak_total,
   output logic        [TOTAL_BITS-1:0]  rsp_valley_total,
   input  logic                          csr_write_en,
   input  logic        [CSR_IDX_BITS-1:0] csr_index,
   input  logic        [MIN_LEN_BITS-1:0] csr_wdata
);

   localparam logic [MIN_LEN_BITS-1:0] MIN_LEN_RESET = MIN_LEN_BITS'(RUN_START_LEN);

   logic [MIN_LEN_BITS-1:0] min_peak_ff, min_peak_in;
   logic [MIN_LEN_BITS-1:0] min_valley_ff, min_valley_in;
   logic [SAMPLE_BITS-1:0]  prev_ff, prev_in;   // offset binary
   logic [SAMPLE_BITS-1:0]  cur;
   logic                    accept, rise;
   trk_ctrl_type            peak_ctrl, valley_ctrl;
   result_type              res_word, rsp_word;

   assign accept = req_valid && req_ready;

   // flip the sign bit so an unsigned compare orders signed samples
   assign cur  = {~req_sample[SAMPLE_BITS-1], req_sample[SAMPLE_BITS-2:0]};
   assign rise = cur > prev_ff;

   assign prev_in = accept ? cur : prev_ff;

   always_comb begin
      min_peak_in   = min_peak_ff;
      min_valley_in = min_valley_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_PEAK_LEN:   min_peak_in   = csr_wdata;
            CSR_MIN_VALLEY_LEN: min_valley_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_peak_ff   <= MIN_LEN_RESET;
         min_valley_ff <= MIN_LEN_RESET;
         prev_ff       <= '0;
      end else begin
         min_peak_ff   <= min_peak_in;
         min_valley_ff <= min_valley_in;
         prev_ff       <= prev_in;
      end
   end

   assign peak_ctrl   = '{accept: accept, first: req_first_sample,
                          last: req_last_sample, lead: rise};
   assign valley_ctrl = '{accept: accept, first: req_first_sample,
                          last: req_last_sample, lead: !rise};

   pvrc_tracker #(.COUNT_BITS(COUNT_BITS)) u_peak (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (peak_ctrl),
      .min_len (min_peak_ff),
      .total   (res_word.peak_total)
   );

   pvrc_tracker #(.COUNT_BITS(COUNT_BITS)) u_valley (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (valley_ctrl),
      .min_len (min_valley_ff),
      .total   (res_word.valley_total)
   );

   pvrc_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && req_last_sample),
      .push_word  (res_word),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_word   (rsp_word)
   );

   assign rsp_peak_total   = rsp_word.peak_total;
   assign rsp_valley_total = rsp_word.valley_total;

`ifndef SYNTHESIS
   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_sample) |=> rsp_valid)
      else $error("last sample accepted without a result word");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");
   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (prev_ff == $past(cur)))
      else $error("previous sample not updated");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for peak_valley_run_counter_core: directed, config sweep,
// backpressure and random sample streams, each checked against a predictor.
// Depends on pvrc_pkg and the peak_valley_run_counter_core RTL.
`timescale 1ns / 1ps

module tb_top;
   import pvrc_pkg::*;

   localparam int LIMIT_CYCLES = 200_000;
   localparam int MAX_PRINTS   = 40;

   typedef struct {
      phase_type   ph;
      logic [15:0] run;
      logic [15:0] tally;
   } run_tracker_type;

   localparam run_tracker_type TRK_CLEAR = '{PH_IDLE, 16'd0, 16'd0};

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [15:0]       req_sample;
   logic                     req_first_sample;
   logic                     req_last_sample;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [TOTAL_BITS-1:0]    rsp_peak_total;
   logic [TOTAL_BITS-1:0]    rsp_valley_total;
   logic                     csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [MIN_LEN_BITS-1:0]  csr_wdata;

   // predictor state
   logic [15:0]        min_peak_cfg;
   logic [15:0]        min_valley_cfg;
   logic signed [15:0] prev_smp;
   run_tracker_type    peak_trk;
   run_tracker_type    valley_trk;
   result_type         totals_q[$];

   int  errors = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   int  hold_request = 0;
   int  hold_left = 0;
   int  stall_left = 0;

   peak_valley_run_counter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_first_sample (req_first_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_peak_total   (rsp_peak_total),
      .rsp_valley_total (rsp_valley_total),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("peak_valley_run_counter_core test failed");
      $finish;
   end

   // ---------------- predictor ----------------

   function automatic logic [15:0] sat_inc(logic [15:0] x);
      return (x == 16'hFFFF) ? x : x + 16'd1;
   endfunction

   // lead = the direction that opens the feature (rise for peaks, fall for valleys)
   function automatic run_tracker_type step_tracker(run_tracker_type t, bit lead,
                                                    logic [15:0] min_len);
      if (lead) begin
         if (t.ph == PH_LEAD) begin
            t.run = sat_inc(t.run);
         end else begin
            if (t.ph == PH_TRAIL && t.run >= min_len) t.tally = sat_inc(t.tally);
            t.ph  = PH_LEAD;
            t.run = 16'(RUN_START_LEN);
         end
      end else if (t.ph == PH_TRAIL) begin
         t.run = sat_inc(t.run);
      end else if (t.ph == PH_LEAD) begin
         if (t.run >= min_len) begin
            t.ph  = PH_TRAIL;
            t.run = 16'(RUN_START_LEN);
         end else begin
            t.ph = PH_IDLE;
         end
      end
      return t;
   endfunction

   // an open trailing run that already qualifies counts at the end of the sequence
   function automatic logic [15:0] closing_total(run_tracker_type t, logic [15:0] min_len);
      return (t.ph == PH_TRAIL && t.run >= min_len) ? sat_inc(t.tally) : t.tally;
   endfunction

   task automatic predict_totals(logic signed [15:0] smp, logic first, logic last);
      bit         rise;
      result_type want;
      if (first) begin
         peak_trk   = TRK_CLEAR;
         valley_trk = TRK_CLEAR;
      end else begin
         rise       = (smp > prev_smp);
         peak_trk   = step_tracker(peak_trk, rise, min_peak_cfg);
         valley_trk = step_tracker(valley_trk, !rise, min_valley_cfg);
      end
      prev_smp = smp;
      if (last) begin
         want.peak_total   = closing_total(peak_trk, min_peak_cfg);
         want.valley_total = closing_total(valley_trk, min_valley_cfg);
         totals_q.push_back(want);
         peak_trk   = TRK_CLEAR;
         valley_trk = TRK_CLEAR;
      end
   endtask

   // ---------------- checking ----------------

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_totals
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (totals_q.size() == 0) begin
            report_mismatch("unexpected result word", rsp_peak_total, -1);
         end else begin
            want = totals_q.pop_front();
            if (rsp_peak_total !== want.peak_total)
               report_mismatch("peak_total", rsp_peak_total, want.peak_total);
            if (rsp_valley_total !== want.valley_total)
               report_mismatch("valley_total", rsp_valley_total, want.valley_total);
         end
      end
   end

   // result side: random stall bursts plus an optional long hold-off
   always @(posedge clock) begin : drive_rsp_ready
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_word(logic signed [15:0] smp, logic first, logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= smp;
      req_first_sample <= first;
      req_last_sample  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      predict_totals(smp, first, last);
   endtask

   // lower valid, wait for every pending result, then let the pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (totals_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_min_lens(logic [15:0] peak_min, logic [15:0] valley_min);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MIN_PEAK_LEN;
      csr_wdata    <= peak_min;
      @(posedge clock);
      csr_index    <= CSR_MIN_VALLEY_LEN;
      csr_wdata    <= valley_min;
      @(posedge clock);
      csr_write_en <= 1'b0;
      min_peak_cfg   = peak_min;
      min_valley_cfg = valley_min;
   endtask

   function automatic int pick_step();
      case ($urandom_range(0, 2))
         0: return 1;
         1: return 60;
         default: return 40000;
      endcase
   endfunction

   function automatic logic [15:0] pick_min_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($urandom_range(0, 6));
      if (r < 9) return 16'($urandom_range(7, 20));
      return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
   endfunction

   // alternating runs of random length; clamping at the rails may turn a rise into a tie
   task automatic send_sequence(int n_runs, int run_max, int step_max, bit with_first);
      int smp_q[$];
      int cur, nxt, len;
      bit up;
      cur = int'($urandom_range(0, 65535)) - 32768;
      smp_q.push_back(cur);
      up = $urandom_range(0, 1);
      repeat (n_runs) begin
         len = $urandom_range(1, run_max);
         repeat (len) begin
            if (up) begin
               nxt = cur + int'($urandom_range(1, step_max));
               if (nxt > 32767) nxt = 32767;
            end else begin
               nxt = cur - int'($urandom_range(0, step_max));
               if (nxt < -32768) nxt = -32768;
            end
            smp_q.push_back(nxt);
            cur = nxt;
         end
         up = !up;
      end
      foreach (smp_q[i])
         send_word(16'(smp_q[i]), with_first && i == 0, i == smp_q.size() - 1);
   endtask

   task automatic send_noise(int n);
      repeat (n)
         send_word(16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 2) == 0);
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      // no opening word after reset: compared against the reset previous sample
      send_word(16'sd0, 1'b0, 1'b0);
      send_word(16'sd0, 1'b0, 1'b0);          // tie counts as a fall
      send_word(16'sd5, 1'b0, 1'b1);
      // after last, a word without first starts a fresh count
      send_word(-16'sd32768, 1'b0, 1'b0);
      send_word(16'sd32767, 1'b0, 1'b1);
      // first and last together
      send_word(16'sd123, 1'b1, 1'b1);
      // rail-to-rail zigzag
      send_word(-16'sd32768, 1'b1, 1'b0);
      send_word(16'sd32767, 1'b0, 1'b0);
      send_word(-16'sd32768, 1'b0, 1'b0);
      send_word(16'sd32767, 1'b0, 1'b0);
      send_word(-16'sd32768, 1'b0, 1'b0);
      send_word(16'sd32767, 1'b0, 1'b1);
      // short runs against a minimum of 3
      drain_results();
      set_min_lens(16'd3, 16'd3);
      send_word(16'sd0, 1'b1, 1'b0);
      send_word(16'sd1, 1'b0, 1'b0);
      send_word(16'sd0, 1'b0, 1'b0);
      send_word(-16'sd1, 1'b0, 1'b0);
      send_word(16'sd0, 1'b0, 1'b0);
      send_word(16'sd1, 1'b0, 1'b0);
      send_word(16'sd2, 1'b0, 1'b1);
      drain_results();
   endtask

   task automatic test_config_sweep();
      int peak_set[7]   = '{0, 1, 65535, 65535, 2, 3, 4};
      int valley_set[7] = '{0, 1, 65535, 0, 2, 5, 1};
      for (int i = 0; i < 7; i++) begin
         drain_results();
         set_min_lens(16'(peak_set[i]), 16'(valley_set[i]));
         repeat (3)
            send_sequence($urandom_range(1, 6), $urandom_range(1, 6), pick_step(), 1'b1);
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      set_min_lens(16'd2, 16'd2);
      idle_on      = 1'b0;
      hold_request = 80;
      // every word closes a sequence, so the result buffer fills and req stalls
      for (int k = 0; k < 24; k++)
         send_word(16'($urandom_range(0, 65535)), k % 3 == 0, 1'b1);
      drain_results();
      // sender pauses mid-sequence until the outstanding result is out
      send_word(-16'sd100, 1'b1, 1'b0);
      send_word(16'sd50, 1'b0, 1'b0);
      send_word(16'sd20, 1'b0, 1'b1);
      send_word(16'sd30, 1'b0, 1'b0);
      drain_results();
      send_word(16'sd40, 1'b0, 1'b0);
      send_word(-16'sd5, 1'b0, 1'b1);
      drain_results();
      idle_on = 1'b1;
   endtask

   task automatic test_random();
      int stop_at, next_cfg;
      stop_at  = items_sent + 720;
      next_cfg = items_sent + 120;
      while (items_sent < stop_at) begin
         if (items_sent >= stop_at - 150) idle_on = 1'b0;
         if (items_sent >= next_cfg) begin
            drain_results();
            set_min_lens(pick_min_len(), pick_min_len());
            next_cfg = items_sent + 120;
         end
         if ($urandom_range(0, 6) == 0)
            send_noise($urandom_range(1, 6));
         else
            send_sequence($urandom_range(1, 6), $urandom_range(1, 8), pick_step(),
                          $urandom_range(0, 9) != 0);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      req_first_sample = 1'b0;
      req_last_sample  = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_MIN_PEAK_LEN;
      csr_wdata        = '0;
      min_peak_cfg     = 16'(RUN_START_LEN);
      min_valley_cfg   = 16'(RUN_START_LEN);
      prev_smp         = -16'sd32768;
      peak_trk         = TRK_CLEAR;
      valley_trk       = TRK_CLEAR;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config_sweep();
      test_backpressure();
      test_random();

      drain_results();
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("peak_valley_run_counter_core test passed");
      end else begin
         $display("peak_valley_run_counter_core test failed");
      end
      $finish;
   end

endmodule

[files.f]
design/pvrc_pkg.sv
design/pvrc_tracker.sv
design/pvrc_out_buf.sv
design/peak_valley_run_counter_core.sv
tb/tb_top.sv
